// File: hdl/rlfs_pkg.sv
package rlfs_pkg;

   // widths fixed by the item fields
   localparam int TIME_WIDTH     = 32;
   localparam int CFG_WIDTH      = 16;
   localparam int ACTIVITY_BITS  = 5;
   localparam int INDEX_WIDTH    = 3;
   localparam int KIND_WIDTH     = 2;
   localparam int TEL_WIDTH      = 8;
   localparam int DATA_WIDTH     = 32;
   localparam int PADDR_WIDTH    = 3;

   // receiver count default and telemetry constants
   localparam int RECEIVER_COUNT_DEFAULT = 5;
   localparam logic [TEL_WIDTH-1:0] TELEMETRY_TYPE = 8'h90;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] SNIFF_RESET   = 16'd25;

   // register indexes
   localparam logic REG_LINK_TIMEOUT   = 1'b0;
   localparam logic REG_SNIFF_INTERVAL = 1'b1;

   // switch kinds
   localparam logic [KIND_WIDTH-1:0] KIND_NONE     = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_FAILOVER = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_SCAN     = 2'd2;

   // configuration seen by the selector
   typedef struct packed {
      logic [CFG_WIDTH-1:0] link_timeout;
      logic [CFG_WIDTH-1:0] sniff_interval;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [ACTIVITY_BITS-1:0] alive_mask;
      logic                     active_valid;
      logic [INDEX_WIDTH-1:0]   active_index;
      logic                     timed_out;
      logic [KIND_WIDTH-1:0]    switch_kind;
      logic [TEL_WIDTH-1:0]     telemetry_check;
   } rsp_type;

endpackage

// File: hdl/rlfs_csr.sv
module rlfs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rlfs_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [rlfs_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic [rlfs_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                             pready,
   output rlfs_pkg::cfg_type                cfg
);

   logic [rlfs_pkg::CFG_WIDTH-1:0] timeout_ff, timeout_in;
   logic [rlfs_pkg::CFG_WIDTH-1:0] interval_ff, interval_in;
   logic                           reg_index;
   logic                           write_en;

   assign reg_index = paddr[2];
   assign write_en  = psel & penable & pwrite;
   assign pready    = 1'b1;

   // register write decode
   always_comb begin
      timeout_in  = timeout_ff;
      interval_in = interval_ff;
      if (write_en) begin
         unique case (reg_index)
            rlfs_pkg::REG_LINK_TIMEOUT:   timeout_in  = pwdata[rlfs_pkg::CFG_WIDTH-1:0];
            rlfs_pkg::REG_SNIFF_INTERVAL: interval_in = pwdata[rlfs_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_index)
         rlfs_pkg::REG_LINK_TIMEOUT:
            prdata = {{(rlfs_pkg::DATA_WIDTH-rlfs_pkg::CFG_WIDTH){1'b0}}, timeout_ff};
         rlfs_pkg::REG_SNIFF_INTERVAL:
            prdata = {{(rlfs_pkg::DATA_WIDTH-rlfs_pkg::CFG_WIDTH){1'b0}}, interval_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= rlfs_pkg::TIMEOUT_RESET;
         interval_ff <= rlfs_pkg::SNIFF_RESET;
      end else begin
         timeout_ff  <= timeout_in;
         interval_ff <= interval_in;
      end
   end

   assign cfg.link_timeout   = timeout_ff;
   assign cfg.sniff_interval = interval_ff;

endmodule

// File: hdl/rlfs_select.sv
module rlfs_select #(
   parameter int RECEIVER_COUNT = rlfs_pkg::RECEIVER_COUNT_DEFAULT,
   parameter int SLOT_WIDTH     = (RECEIVER_COUNT > 1) ? $clog2(RECEIVER_COUNT) : 1
) (
   input  logic [rlfs_pkg::TIME_WIDTH-1:0]    now_time,
   input  logic [rlfs_pkg::ACTIVITY_BITS-1:0] activity,
   input  rlfs_pkg::cfg_type                  cfg,
   input  logic [RECEIVER_COUNT-1:0]          seen,
   input  logic [rlfs_pkg::TIME_WIDTH-1:0]    last_seen [RECEIVER_COUNT],
   input  logic                               present,
   input  logic [SLOT_WIDTH-1:0]              slot,
   input  logic [rlfs_pkg::TIME_WIDTH-1:0]    last_sniff,
   input  logic [SLOT_WIDTH-1:0]              sniff_ptr,
   output logic [RECEIVER_COUNT-1:0]          seen_next,
   output logic [rlfs_pkg::TIME_WIDTH-1:0]    last_seen_next [RECEIVER_COUNT],
   output logic                               present_next,
   output logic [SLOT_WIDTH-1:0]              slot_next,
   output logic [rlfs_pkg::TIME_WIDTH-1:0]    last_sniff_next,
   output logic [SLOT_WIDTH-1:0]              sniff_ptr_next,
   output rlfs_pkg::rsp_type                  rsp
);

   localparam logic [SLOT_WIDTH-1:0] LAST_SLOT = SLOT_WIDTH'(RECEIVER_COUNT - 1);

   logic [RECEIVER_COUNT-1:0]       has_bytes;
   logic [RECEIVER_COUNT-1:0]       mark;
   logic [RECEIVER_COUNT-1:0]       mark_scan;
   logic [RECEIVER_COUNT-1:0]       alive;
   logic [rlfs_pkg::TIME_WIDTH-1:0] sniff_age;
   logic                            sniff_due;
   logic [SLOT_WIDTH-1:0]           ptr_step;
   logic [SLOT_WIDTH-1:0]           ptr_pick;
   logic                            timeout_live;
   logic                            dropped;
   logic                            still_active;
   logic                            alive_any;
   logic [SLOT_WIDTH-1:0]           failover_slot;
   logic                            bytes_any;
   logic [SLOT_WIDTH-1:0]           scan_slot;
   logic                            take_scan;
   logic [rlfs_pkg::ACTIVITY_BITS-1:0] mask;
   logic [rlfs_pkg::KIND_WIDTH-1:0] kind;

   function automatic logic [SLOT_WIDTH-1:0] step_slot(input logic [SLOT_WIDTH-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // receivers without an activity bit never show bytes
   genvar g;
   generate
      for (g = 0; g < RECEIVER_COUNT; g++) begin : g_rx
         if (g < rlfs_pkg::ACTIVITY_BITS) begin : g_act
            assign has_bytes[g] = activity[g];
         end else begin : g_noact
            assign has_bytes[g] = 1'b0;
         end
      end
   endgenerate

   // background sample, pointer skips the active receiver
   assign sniff_age = now_time - last_sniff;
   assign sniff_due = present &&
                      (sniff_age >= {{(rlfs_pkg::TIME_WIDTH-rlfs_pkg::CFG_WIDTH){1'b0}},
                                     cfg.sniff_interval});
   assign ptr_step  = step_slot(sniff_ptr);
   assign ptr_pick  = (ptr_step == slot) ? step_slot(ptr_step) : ptr_step;

   assign timeout_live = (cfg.link_timeout != '0);

   // refresh marks and liveness per receiver
   always_comb begin
      logic [rlfs_pkg::TIME_WIDTH-1:0] age;
      for (int i = 0; i < RECEIVER_COUNT; i++) begin
         mark[i] = present && has_bytes[i] &&
                   ((SLOT_WIDTH'(i) == slot) || (sniff_due && (SLOT_WIDTH'(i) == ptr_pick)));
         age = now_time - last_seen[i];
         alive[i] = mark[i] ? timeout_live :
                    (seen[i] &&
                     (age < {{(rlfs_pkg::TIME_WIDTH-rlfs_pkg::CFG_WIDTH){1'b0}},
                             cfg.link_timeout}));
      end
   end

   // drop check on the active receiver
   always_comb begin
      dropped = 1'b0;
      for (int i = 0; i < RECEIVER_COUNT; i++) begin
         if (present && (SLOT_WIDTH'(i) == slot) && !alive[i]) dropped = 1'b1;
      end
   end
   assign still_active = present && !dropped;

   // lowest alive receiver and lowest receiver with bytes
   always_comb begin
      alive_any     = 1'b0;
      failover_slot = '0;
      bytes_any     = 1'b0;
      scan_slot     = '0;
      for (int i = RECEIVER_COUNT - 1; i >= 0; i--) begin
         if (alive[i]) begin
            alive_any     = 1'b1;
            failover_slot = SLOT_WIDTH'(i);
         end
         if (has_bytes[i]) begin
            bytes_any = 1'b1;
            scan_slot = SLOT_WIDTH'(i);
         end
      end
   end

   assign take_scan = !still_active && !alive_any && bytes_any;

   // new active receiver and switch kind
   always_comb begin
      kind = rlfs_pkg::KIND_NONE;
      if (still_active) begin
         slot_next = slot;
      end else if (alive_any) begin
         slot_next = failover_slot;
         kind      = rlfs_pkg::KIND_FAILOVER;
      end else if (bytes_any) begin
         slot_next = scan_slot;
         kind      = rlfs_pkg::KIND_SCAN;
      end else begin
         slot_next = '0;
      end
   end
   assign present_next = still_active || alive_any || bytes_any;

   // last-seen updates
   always_comb begin
      for (int i = 0; i < RECEIVER_COUNT; i++) begin
         mark_scan[i]      = take_scan && (SLOT_WIDTH'(i) == scan_slot);
         seen_next[i]      = seen[i] || mark[i] || mark_scan[i];
         last_seen_next[i] = (mark[i] || mark_scan[i]) ? now_time : last_seen[i];
      end
   end

   assign last_sniff_next = sniff_due ? now_time : last_sniff;
   assign sniff_ptr_next  = sniff_due ? ptr_pick : sniff_ptr;

   // alive mask covers the first five receivers only
   generate
      for (g = 0; g < rlfs_pkg::ACTIVITY_BITS; g++) begin : g_mask
         if (g < RECEIVER_COUNT) begin : g_have
            assign mask[g] = alive[g];
         end else begin : g_none
            assign mask[g] = 1'b0;
         end
      end
   endgenerate

   assign rsp.alive_mask      = mask;
   assign rsp.active_valid    = present_next;
   assign rsp.active_index    = rlfs_pkg::INDEX_WIDTH'(slot_next);
   assign rsp.timed_out       = dropped;
   assign rsp.switch_kind     = kind;
   assign rsp.telemetry_check = rlfs_pkg::TELEMETRY_TYPE ^
                                {{(rlfs_pkg::TEL_WIDTH-1){1'b0}}, ^mask};

endmodule

// File: hdl/receiver_link_failover_selector_core.sv
// Receiver link failover selector. Each item on the req channel is one tick: a wrapping
// millisecond time and a mask of receivers with bytes waiting. For each tick the block
// refreshes the active receiver, takes a round-robin background sample of another receiver
// once the sniff interval has passed, drops an active receiver that has timed out, and fails
// over to the lowest alive receiver or locks onto the lowest one with bytes. One result item
// comes back per tick. Ticks are taken one per cycle unless rsp_ready stalls. An input and a
// result register hold each, with the per-tick decision in one stage between them, which
// also holds the receiver state. The result register lets a new tick enter while the previous
// result waits. Write link timeout (offset 0x0) and sniff interval (offset 0x4) over the APB
// port only while no tick is in flight; the block does not check. Both reset to 50 and 25 ms.
module receiver_link_failover_selector_core #(
   parameter int RECEIVER_COUNT = rlfs_pkg::RECEIVER_COUNT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [rlfs_pkg::TIME_WIDTH-1:0]        req_now_time,
   input  logic [rlfs_pkg::ACTIVITY_BITS-1:0]     req_activity,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rlfs_pkg::ACTIVITY_BITS-1:0]     rsp_alive_mask,
   output logic                                   rsp_active_valid,
   output logic [rlfs_pkg::INDEX_WIDTH-1:0]       rsp_active_index,
   output logic                                   rsp_timed_out,
   output logic [rlfs_pkg::KIND_WIDTH-1:0]        rsp_switch_kind,
   output logic [rlfs_pkg::TEL_WIDTH-1:0]         rsp_telemetry_check,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [rlfs_pkg::PADDR_WIDTH-1:0]       paddr,
   input  logic [rlfs_pkg::DATA_WIDTH-1:0]        pwdata,
   output logic [rlfs_pkg::DATA_WIDTH-1:0]        prdata,
   output logic                                   pready
);

   localparam int SLOT_WIDTH = (RECEIVER_COUNT > 1) ? $clog2(RECEIVER_COUNT) : 1;

   rlfs_pkg::cfg_type cfg;
   rlfs_pkg::rsp_type rsp_next;
   rlfs_pkg::rsp_type rsp_ff;

   logic                               in_valid_ff;
   logic [rlfs_pkg::TIME_WIDTH-1:0]    in_now_ff;
   logic [rlfs_pkg::ACTIVITY_BITS-1:0] in_act_ff;
   logic                               rsp_valid_ff;
   logic                               advance;
   logic                               req_take;

   logic [RECEIVER_COUNT-1:0]          seen_ff, seen_in;
   logic [rlfs_pkg::TIME_WIDTH-1:0]    last_seen_ff [RECEIVER_COUNT];
   logic [rlfs_pkg::TIME_WIDTH-1:0]    last_seen_in [RECEIVER_COUNT];
   logic                               present_ff, present_in;
   logic [SLOT_WIDTH-1:0]              slot_ff, slot_in;
   logic [rlfs_pkg::TIME_WIDTH-1:0]    last_sniff_ff, last_sniff_in;
   logic [SLOT_WIDTH-1:0]              sniff_ptr_ff, sniff_ptr_in;

   // configuration registers
   rlfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // per-tick decision
   rlfs_select #(
      .RECEIVER_COUNT (RECEIVER_COUNT),
      .SLOT_WIDTH     (SLOT_WIDTH)
   ) u_select (
      .now_time        (in_now_ff),
      .activity        (in_act_ff),
      .cfg             (cfg),
      .seen            (seen_ff),
      .last_seen       (last_seen_ff),
      .present         (present_ff),
      .slot            (slot_ff),
      .last_sniff      (last_sniff_ff),
      .sniff_ptr       (sniff_ptr_ff),
      .seen_next       (seen_in),
      .last_seen_next  (last_seen_in),
      .present_next    (present_in),
      .slot_next       (slot_in),
      .last_sniff_next (last_sniff_in),
      .sniff_ptr_next  (sniff_ptr_in),
      .rsp             (rsp_next)
   );

   // handshake: evaluate when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!in_valid_ff || advance);
   assign req_take  = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff <= req_now_time;
         in_act_ff <= req_activity;
      end
   end

   // receiver state, updated once per evaluated item
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= '0;
         present_ff    <= 1'b0;
         slot_ff       <= '0;
         last_sniff_ff <= '0;
         sniff_ptr_ff  <= '0;
         for (int i = 0; i < RECEIVER_COUNT; i++) last_seen_ff[i] <= '0;
      end else if (advance) begin
         seen_ff       <= seen_in;
         present_ff    <= present_in;
         slot_ff       <= slot_in;
         last_sniff_ff <= last_sniff_in;
         sniff_ptr_ff  <= sniff_ptr_in;
         for (int i = 0; i < RECEIVER_COUNT; i++) last_seen_ff[i] <= last_seen_in[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_next;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_alive_mask      = rsp_ff.alive_mask;
   assign rsp_active_valid    = rsp_ff.active_valid;
   assign rsp_active_index    = rsp_ff.active_index;
   assign rsp_timed_out       = rsp_ff.timed_out;
   assign rsp_switch_kind     = rsp_ff.switch_kind;
   assign rsp_telemetry_check = rsp_ff.telemetry_check;

endmodule
